// ===== rtl/core/eto_pkg.sv =====
// ----------------------------------------------------------------------------
// eto_pkg
// Shared types, register indexes and the sine table generator for the
// encoder tick odometry block.
// ----------------------------------------------------------------------------
package eto_pkg;

  // sine and cosine magnitudes, +1.0 is 65536
  localparam int unsigned SINE_W = 17;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // fixed-point pi/2 in Q30
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  // taylor series divisors (2k)(2k+1) for k = 1..10
  localparam longint unsigned TaylorDiv [10] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
    64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FWD_STEP  = 3'd0,
    REG_SIDE_STEP = 3'd1,
    REG_TURN_STEP = 3'd2,
    REG_START_X   = 3'd3,
    REG_START_Y   = 3'd4,
    REG_START_HDG = 3'd5
  } eto_reg_e;

  typedef struct packed {
    logic kind;
    logic left_wheel;
    logic clockwise;
  } eto_in_t;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic [23:0]        pose_heading;
  } eto_out_t;

  typedef struct packed {
    logic [15:0]        tick_forward_step;
    logic [15:0]        tick_sideways_step;
    logic [19:0]        tick_turn_step;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic [23:0]        start_heading;
  } eto_cfg_t;

  // one quarter-wave entry, evaluated at elaboration only
  function automatic logic [SINE_W-1:0] sine_entry(int unsigned idx, int unsigned addr_bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned r;
    longint          sum;
    x    = (HalfPiQ30 * longint'(idx) + ((64'd1 << addr_bits) >> 1)) >> addr_bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 10; k++) begin
      term = (term * x2) >> 30;
      term = term / TaylorDiv[k-1];
      if ((k % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) sum = 0;
    if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
    r = (longint'(sum) + 64'd8192) >> 14;
    if (r > 64'd65536) r = 64'd65536;
    return SINE_W'(r);
  endfunction

endpackage

// ===== rtl/core/eto_sine_rom.sv =====
// ----------------------------------------------------------------------------
// eto_sine_rom
// Quarter-wave sine table with two registered read ports.
// ----------------------------------------------------------------------------
module eto_sine_rom import eto_pkg::*; #(
  parameter int unsigned ADDR_BITS = 10
) (
  input  logic                 clk_i,
  input  logic [ADDR_BITS:0]   addr_a_i,
  input  logic [ADDR_BITS:0]   addr_b_i,
  output logic [SINE_W-1:0]    data_a_o,
  output logic [SINE_W-1:0]    data_b_o
);

  localparam int unsigned Depth = (1 << ADDR_BITS) + 1;

  logic [SINE_W-1:0] rom [Depth];
  logic [SINE_W-1:0] data_a_q;
  logic [SINE_W-1:0] data_b_q;

  for (genvar g = 0; g < Depth; g++) begin : g_entry
    assign rom[g] = sine_entry(g, ADDR_BITS);
  end

  always_ff @(posedge clk_i) begin
    data_a_q <= rom[addr_a_i];
    data_b_q <= rom[addr_b_i];
  end

  assign data_a_o = data_a_q;
  assign data_b_o = data_b_q;

endmodule

// ===== rtl/core/eto_pose_step.sv =====
// ----------------------------------------------------------------------------
// eto_pose_step
// Next-pose logic: rotates the tick step by the heading, rounds, adds with
// saturation and steps the heading; or reloads the start pose.
// ----------------------------------------------------------------------------
module eto_pose_step import eto_pkg::*; #(
  parameter int unsigned ANGLE_BITS    = 24,
  parameter int unsigned POSITION_BITS = 32
) (
  input  eto_in_t                         item_i,
  input  eto_cfg_t                        cfg_i,
  input  logic signed [POSITION_BITS-1:0] pos_x_i,
  input  logic signed [POSITION_BITS-1:0] pos_y_i,
  input  logic [ANGLE_BITS-1:0]           heading_i,
  input  logic [1:0]                      quad_i,
  input  logic [SINE_W-1:0]               tbl_a_i,
  input  logic [SINE_W-1:0]               tbl_b_i,
  output logic signed [POSITION_BITS-1:0] pos_x_o,
  output logic signed [POSITION_BITS-1:0] pos_y_o,
  output logic [ANGLE_BITS-1:0]           heading_o
);

  localparam int unsigned P   = POSITION_BITS;
  localparam int unsigned Ext = (POSITION_BITS > 32) ? POSITION_BITS : 32;
  localparam logic signed [P-1:0] PosMax = {1'b0, {(P-1){1'b1}}};
  localparam logic signed [P-1:0] PosMin = {1'b1, {(P-1){1'b0}}};

  logic               forward;
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [17:0] sin_v;
  logic signed [17:0] cos_v;
  logic [SINE_W-1:0]  sin_mag;
  logic [SINE_W-1:0]  cos_mag;
  logic signed [34:0] p_xc;
  logic signed [34:0] p_ys;
  logic signed [34:0] p_xs;
  logic signed [34:0] p_yc;
  logic signed [35:0] vx;
  logic signed [35:0] vy;
  logic signed [19:0] ax;
  logic signed [19:0] ay;
  logic signed [P:0]  sum_x;
  logic signed [P:0]  sum_y;
  logic signed [Ext-1:0] sx_e;
  logic signed [Ext-1:0] sy_e;
  logic [ANGLE_BITS-1:0] turn;

  assign forward = item_i.left_wheel ^ item_i.clockwise;
  assign dx = forward ? 17'(cfg_i.tick_forward_step) : -17'(cfg_i.tick_forward_step);
  assign dy = item_i.left_wheel ? -17'(cfg_i.tick_sideways_step)
                                : 17'(cfg_i.tick_sideways_step);

  // table port a reads the offset, port b its mirror; odd quadrants swap them
  assign sin_mag = quad_i[0] ? tbl_b_i : tbl_a_i;
  assign cos_mag = quad_i[0] ? tbl_a_i : tbl_b_i;
  assign sin_v   = quad_i[1] ? -18'(sin_mag) : 18'(sin_mag);
  assign cos_v   = (quad_i[1] ^ quad_i[0]) ? -18'(cos_mag) : 18'(cos_mag);

  assign p_xc = 35'(dx) * 35'(cos_v);
  assign p_ys = 35'(dy) * 35'(sin_v);
  assign p_xs = 35'(dx) * 35'(sin_v);
  assign p_yc = 35'(dy) * 35'(cos_v);
  assign vx   = 36'(p_xc) - 36'(p_ys) + 36'sd32768;
  assign vy   = 36'(p_xs) + 36'(p_yc) + 36'sd32768;
  assign ax   = vx[35:16];
  assign ay   = vy[35:16];

  assign sum_x = (P+1)'(pos_x_i) + (P+1)'(ax);
  assign sum_y = (P+1)'(pos_y_i) + (P+1)'(ay);

  assign sx_e = Ext'(cfg_i.start_x);
  assign sy_e = Ext'(cfg_i.start_y);
  assign turn = ANGLE_BITS'(cfg_i.tick_turn_step);

  always_comb begin
    if (item_i.kind) begin
      if (sx_e > Ext'(PosMax)) pos_x_o = PosMax;
      else if (sx_e < Ext'(PosMin)) pos_x_o = PosMin;
      else pos_x_o = P'(sx_e);
      if (sy_e > Ext'(PosMax)) pos_y_o = PosMax;
      else if (sy_e < Ext'(PosMin)) pos_y_o = PosMin;
      else pos_y_o = P'(sy_e);
      heading_o = ANGLE_BITS'(cfg_i.start_heading);
    end else begin
      // overflow when the two top bits of the sum disagree
      if (sum_x[P] != sum_x[P-1]) pos_x_o = sum_x[P] ? PosMin : PosMax;
      else pos_x_o = sum_x[P-1:0];
      if (sum_y[P] != sum_y[P-1]) pos_y_o = sum_y[P] ? PosMin : PosMax;
      else pos_y_o = sum_y[P-1:0];
      heading_o = item_i.clockwise ? heading_i + turn : heading_i - turn;
    end
  end

endmodule

// ===== rtl/core/encoder_tick_odometry.sv =====
// ----------------------------------------------------------------------------
// encoder_tick_odometry
// Dead-reckoning pose tracker driven by wheel-encoder ticks.
// ----------------------------------------------------------------------------
// two register stages: input register, then the pose registers that also
// serve as result. throughput: one item per cycle unless the output stalls;
// the sine table is read ahead from the next heading so lookup, four
// multiplies and adds fit one stage
// reset: pose is 90 mm, 36 mm, a quarter turn; registers take their defaults
// ----------------------------------------------------------------------------
module encoder_tick_odometry import eto_pkg::*; #(
  parameter int unsigned ANGLE_BITS           = 24,
  parameter int unsigned POSITION_BITS        = 32,
  parameter int unsigned SINE_TABLE_ADDR_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  eto_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output eto_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned A  = ANGLE_BITS;
  localparam int unsigned P  = POSITION_BITS;
  localparam int unsigned SA = SINE_TABLE_ADDR_BITS;
  localparam int unsigned Ph = SA + 2;

  localparam longint PosMaxL = (64'sd1 <<< (P - 1)) - 64'sd1;
  localparam longint ResetXL = (64'sd5898240 > PosMaxL) ? PosMaxL : 64'sd5898240;
  localparam longint ResetYL = (64'sd2359296 > PosMaxL) ? PosMaxL : 64'sd2359296;
  localparam logic signed [P-1:0] ResetX = P'(ResetXL);
  localparam logic signed [P-1:0] ResetY = P'(ResetYL);
  localparam logic [A-1:0]        ResetHdg = A'(64'd1 << (A - 2));
  localparam logic [23:0]         ResetStartHdg = 24'(64'd1 << (A - 2));

  eto_cfg_t cfg_q;

  logic    s1_valid_q;
  eto_in_t s1_item_q;
  logic    out_valid_q;
  logic    adv;
  logic    accept;

  logic signed [P-1:0] pos_x_q;
  logic signed [P-1:0] pos_y_q;
  logic [A-1:0]        heading_q;
  logic signed [P-1:0] pos_x_n;
  logic signed [P-1:0] pos_y_n;
  logic [A-1:0]        heading_n;
  logic [A-1:0]        heading_d;

  logic [Ph-1:0]     phase_d;
  logic [SA-1:0]     off_d;
  logic [SA:0]       addr_a;
  logic [SA:0]       addr_b;
  logic [1:0]        quad_q;
  logic [SINE_W-1:0] tbl_a;
  logic [SINE_W-1:0] tbl_b;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_forward_step  <= 16'd13940;
      cfg_q.tick_sideways_step <= 16'd41;
      cfg_q.tick_turn_step     <= 20'd15673;
      cfg_q.start_x            <= 32'sd5898240;
      cfg_q.start_y            <= 32'sd2359296;
      cfg_q.start_heading      <= ResetStartHdg;
    end else if (cfg_we_i) begin
      case (eto_reg_e'(cfg_index_i))
        REG_FWD_STEP:  cfg_q.tick_forward_step  <= cfg_data_i[15:0];
        REG_SIDE_STEP: cfg_q.tick_sideways_step <= cfg_data_i[15:0];
        REG_TURN_STEP: cfg_q.tick_turn_step     <= cfg_data_i[19:0];
        REG_START_X:   cfg_q.start_x            <= cfg_data_i;
        REG_START_Y:   cfg_q.start_y            <= cfg_data_i;
        REG_START_HDG: cfg_q.start_heading      <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // handshake: input stage advances into the pose registers when the result
  // register is empty or being taken
  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= accept || (s1_valid_q && !adv);
      out_valid_q <= adv || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_data_i;
    end
  end

  // pose state doubles as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= ResetX;
      pos_y_q   <= ResetY;
      heading_q <= ResetHdg;
    end else if (adv) begin
      pos_x_q   <= pos_x_n;
      pos_y_q   <= pos_y_n;
      heading_q <= heading_n;
    end
  end

  assign heading_d = adv ? heading_n : heading_q;

  // table phase taken from the heading that will be current next cycle
  if (A >= Ph) begin : g_phase_shr
    assign phase_d = heading_d[A-1 -: Ph];
  end else begin : g_phase_shl
    assign phase_d = {heading_d, {(Ph - A){1'b0}}};
  end

  assign off_d  = phase_d[SA-1:0];
  assign addr_a = {1'b0, off_d};
  assign addr_b = {1'b1, {SA{1'b0}}} - {1'b0, off_d};

  always_ff @(posedge clk_i) begin
    quad_q <= phase_d[Ph-1 -: 2];
  end

  eto_sine_rom #(
    .ADDR_BITS (SA)
  ) u_sine_rom (
    .clk_i    (clk_i),
    .addr_a_i (addr_a),
    .addr_b_i (addr_b),
    .data_a_o (tbl_a),
    .data_b_o (tbl_b)
  );

  eto_pose_step #(
    .ANGLE_BITS    (A),
    .POSITION_BITS (P)
  ) u_pose_step (
    .item_i    (s1_item_q),
    .cfg_i     (cfg_q),
    .pos_x_i   (pos_x_q),
    .pos_y_i   (pos_y_q),
    .heading_i (heading_q),
    .quad_i    (quad_q),
    .tbl_a_i   (tbl_a),
    .tbl_b_i   (tbl_b),
    .pos_x_o   (pos_x_n),
    .pos_y_o   (pos_y_n),
    .heading_o (heading_n)
  );

  assign out_valid_o             = out_valid_q;
  assign out_data_o.pose_x       = 32'($unsigned(pos_x_q));
  assign out_data_o.pose_y       = 32'($unsigned(pos_y_q));
  assign out_data_o.pose_heading = 24'(heading_q);

endmodule

// ===== dv/encoder_tick_odometry_test.sv =====
// ----------------------------------------------------------------------------
// encoder_tick_odometry_test
// Self-checking bench for the encoder tick odometry block. Each accepted tick
// or reload word updates a local pose tracker, built on its own quarter-wave
// sine table, and every pose that the block returns is compared with the
// oldest pending prediction. Directed tests cover reset defaults, register
// extremes and masking, position saturation, heading wrap and quadrants. A
// random part then sweeps many register setups under random idling on both
// sides.
// ----------------------------------------------------------------------------
module encoder_tick_odometry_test;
  timeunit 1ns;
  timeprecision 1ps;

  import eto_pkg::*;

  localparam int unsigned LutBits = 10;
  localparam int unsigned LutSize = 1 << LutBits;
  localparam int unsigned PhaseW = LutBits + 2;
  localparam longint unsigned QuarterTurnQ30 = 64'd1686629713;
  localparam longint PosMax = 64'sd2147483647;
  localparam longint PosMin = -PosMax - 1;
  localparam int unsigned ResultLatency = 2;
  localparam int unsigned RandomWords = 1750;
  localparam int unsigned LastStretchWords = 150;
  localparam logic [CFG_IDX_W-1:0] RegUnusedLo = 3'd6;
  localparam logic [CFG_IDX_W-1:0] RegUnusedHi = 3'd7;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid;
  logic                  in_stall;
  eto_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  eto_out_t              out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // pose tracker and register shadow
  int unsigned sine_lut [0:LutSize];
  eto_cfg_t    shadow_cfg;
  longint      track_x;
  longint      track_y;
  logic [23:0] track_heading;
  eto_out_t    pending_poses [$];

  bit          idle_enable;
  int unsigned stall_left;
  int unsigned error_count;
  int unsigned words_sent;
  int unsigned poses_checked;
  int unsigned reg_writes;
  int unsigned setups;

  encoder_tick_odometry DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // one quarter-wave entry: taylor series in Q30, rounded to Q16
  function automatic int unsigned quarter_sine(int unsigned idx);
    longint unsigned arg;
    longint unsigned arg_sq;
    longint unsigned term;
    longint unsigned scaled;
    longint          acc;
    int              k;
    arg    = (QuarterTurnQ30 * 64'(idx) + 64'(LutSize >> 1)) >> LutBits;
    arg_sq = (arg * arg) >> 30;
    term   = arg;
    acc    = longint'(arg);
    for (k = 1; k <= 10; k++) begin
      term = (term * arg_sq) >> 30;
      term = term / longint'(4 * k * k + 2 * k);
      if ((k % 2) == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
    scaled = (acc + 8192) >> 14;
    if (scaled > 65536) scaled = 65536;
    return scaled[31:0];
  endfunction

  function automatic longint lut_sine(logic [PhaseW-1:0] ph);
    int unsigned off;
    int unsigned mag;
    off = 32'(ph[LutBits-1:0]);
    mag = ph[LutBits] ? sine_lut[LutSize - off] : sine_lut[off];
    return ph[LutBits+1] ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint round_q16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic longint sat_pos(longint v);
    if (v > PosMax) return PosMax;
    if (v < PosMin) return PosMin;
    return v;
  endfunction

  // update the tracker with an accepted word and queue the pose it yields
  task automatic advance_pose(input eto_in_t w);
    logic              fwd;
    longint            dx;
    longint            dy;
    longint            s;
    longint            c;
    logic [PhaseW-1:0] ph;
    logic [PhaseW-1:0] cos_ph;
    eto_out_t          pose;
    if (w.kind) begin
      track_x       = longint'(shadow_cfg.start_x);
      track_y       = longint'(shadow_cfg.start_y);
      track_heading = shadow_cfg.start_heading;
    end else begin
      fwd    = w.left_wheel != w.clockwise;
      dx     = fwd ? longint'(shadow_cfg.tick_forward_step)
                   : -longint'(shadow_cfg.tick_forward_step);
      dy     = w.left_wheel ? -longint'(shadow_cfg.tick_sideways_step)
                            : longint'(shadow_cfg.tick_sideways_step);
      ph     = track_heading[23 -: PhaseW];
      cos_ph = ph + PhaseW'(LutSize);
      s      = lut_sine(ph);
      c      = lut_sine(cos_ph);
      track_x = sat_pos(track_x + round_q16(dx * c - dy * s));
      track_y = sat_pos(track_y + round_q16(dx * s + dy * c));
      if (w.clockwise) track_heading = track_heading + 24'(shadow_cfg.tick_turn_step);
      else track_heading = track_heading - 24'(shadow_cfg.tick_turn_step);
    end
    pose.pose_x       = track_x[31:0];
    pose.pose_y       = track_y[31:0];
    pose.pose_heading = track_heading;
    pending_poses = {pending_poses, pose};
  endtask

  task automatic send_word(input eto_in_t w);
    int unsigned gap;
    gap = 0;
    if (idle_enable && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 17);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data  = w;
    do @(posedge clk_i); while (in_stall);
    advance_pose(w);
    words_sent++;
  endtask

  task automatic send_tick(input logic left, input logic cw);
    eto_in_t w;
    w.kind       = 1'b0;
    w.left_wheel = left;
    w.clockwise  = cw;
    send_word(w);
  endtask

  // wheel and direction bits are don't-care on a reload
  task automatic send_reload();
    eto_in_t w;
    w.kind       = 1'b1;
    w.left_wheel = 1'($urandom_range(0, 1));
    w.clockwise  = 1'($urandom_range(0, 1));
    send_word(w);
  endtask

  // sender holds off until every pending pose has come back
  task automatic drain_poses();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (pending_poses.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    case (idx)
      REG_FWD_STEP:  shadow_cfg.tick_forward_step  = data[15:0];
      REG_SIDE_STEP: shadow_cfg.tick_sideways_step = data[15:0];
      REG_TURN_STEP: shadow_cfg.tick_turn_step     = data[19:0];
      REG_START_X:   shadow_cfg.start_x            = data;
      REG_START_Y:   shadow_cfg.start_y            = data;
      REG_START_HDG: shadow_cfg.start_heading      = data[23:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // zero, all ones or random in the field, with junk above it
  function automatic logic [31:0] field_value(int unsigned width);
    logic [31:0] mask;
    logic [31:0] base;
    mask = (width >= 32) ? '1 : (32'd1 << width) - 1;
    case ($urandom_range(0, 3))
      0: base = '0;
      1: base = mask;
      default: base = $urandom & mask;
    endcase
    return base | ($urandom & ~mask);
  endfunction

  function automatic logic [31:0] start_value();
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 262143);
      1: return 32'h8000_0000 + $urandom_range(0, 262143);
      2: return $urandom_range(0, 1) ? ($urandom & 32'h00FF_FFFF)
                                     : -($urandom & 32'h00FF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  task automatic randomize_setup();
    if ($urandom_range(0, 3) != 0) cfg_write(REG_FWD_STEP, field_value(16));
    if ($urandom_range(0, 3) != 0) cfg_write(REG_SIDE_STEP, field_value(16));
    if ($urandom_range(0, 3) != 0) cfg_write(REG_TURN_STEP, field_value(20));
    if ($urandom_range(0, 3) != 0) cfg_write(REG_START_X, start_value());
    if ($urandom_range(0, 3) != 0) cfg_write(REG_START_Y, start_value());
    if ($urandom_range(0, 3) != 0) cfg_write(REG_START_HDG, field_value(24));
    if ($urandom_range(0, 5) == 0) begin
      cfg_write($urandom_range(0, 1) ? RegUnusedHi : RegUnusedLo, $urandom);
    end
    setups++;
  endtask

  // ticks from the reset pose with default steps, then two reloads of the
  // default start pose
  task automatic test_reset_defaults();
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_reload();
    send_reload();
  endtask

  task automatic test_register_extremes();
    drain_poses();
    cfg_write(REG_FWD_STEP, 32'hFFFF_FFFF);
    cfg_write(REG_SIDE_STEP, 32'hFFFF_FFFF);
    cfg_write(REG_TURN_STEP, 32'hFFFF_FFFF);
    cfg_write(RegUnusedLo, $urandom);
    cfg_write(RegUnusedHi, $urandom);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    drain_poses();
    cfg_write(REG_FWD_STEP, 32'hABCD_0000);
    cfg_write(REG_SIDE_STEP, 32'h5A5A_0000);
    cfg_write(REG_TURN_STEP, 32'hFFF0_0000);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
  endtask

  // heading zero so steps land on the axes and push into both rails
  task automatic test_saturation();
    drain_poses();
    cfg_write(REG_FWD_STEP, 32'h0000_FFFF);
    cfg_write(REG_SIDE_STEP, 32'h0000_FFFF);
    cfg_write(REG_TURN_STEP, 32'h0000_0000);
    cfg_write(REG_START_X, 32'h7FFF_FFF0);
    cfg_write(REG_START_Y, 32'h8000_000F);
    cfg_write(REG_START_HDG, 32'hFF00_0000);
    send_reload();
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    drain_poses();
    cfg_write(REG_START_X, 32'h8000_0005);
    cfg_write(REG_START_Y, 32'h7FFF_FFFA);
    send_reload();
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
  endtask

  task automatic test_heading_wrap();
    drain_poses();
    cfg_write(REG_FWD_STEP, 32'd13940);
    cfg_write(REG_SIDE_STEP, 32'd41);
    cfg_write(REG_TURN_STEP, 32'h000F_FFFF);
    cfg_write(REG_START_HDG, 32'h0000_0010);
    send_reload();
    send_tick(1'b0, 1'b0);
    drain_poses();
    cfg_write(REG_START_HDG, 32'h00FF_FFFF);
    send_reload();
    send_tick(1'b1, 1'b1);
  endtask

  task automatic test_quadrants();
    drain_poses();
    cfg_write(REG_START_HDG, 32'h0080_0000);
    send_reload();
    send_tick(1'b1, 1'b0);
    drain_poses();
    cfg_write(REG_START_HDG, 32'h00C0_0000);
    send_reload();
    send_tick(1'b0, 1'b1);
  endtask

  task automatic test_random_traffic();
    int unsigned random_words;
    int unsigned phase_len;
    int unsigned n;
    eto_in_t     w;
    random_words = 0;
    while (random_words < RandomWords + LastStretchWords) begin
      drain_poses();
      randomize_setup();
      if (random_words >= RandomWords) begin
        idle_enable = 1'b0;
        phase_len   = LastStretchWords;
      end else begin
        idle_enable = ($urandom_range(0, 3) != 0);
        phase_len   = $urandom_range(30, 150);
      end
      if ($urandom_range(0, 4) != 0) begin
        send_reload();
        random_words++;
      end
      for (n = 0; n < phase_len; n++) begin
        w.kind       = ($urandom_range(0, 24) == 0);
        w.left_wheel = 1'($urandom_range(0, 1));
        w.clockwise  = 1'($urandom_range(0, 1));
        send_word(w);
        random_words++;
      end
    end
  endtask

  // receiver stall bursts
  always @(negedge clk_i) begin
    if (!idle_enable) begin
      stall_left = 0;
      out_stall  = 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      out_stall  = 1'b1;
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_pose
    eto_out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_poses.size() == 0) begin
        $error("pose word with none pending: x %0d y %0d heading %0h",
               out_data.pose_x, out_data.pose_y, out_data.pose_heading);
        error_count++;
      end else begin
        want = pending_poses.pop_front();
        poses_checked++;
        if (out_data.pose_x !== want.pose_x) begin
          $error("pose_x expected %0d actual %0d", want.pose_x, out_data.pose_x);
          error_count++;
        end
        if (out_data.pose_y !== want.pose_y) begin
          $error("pose_y expected %0d actual %0d", want.pose_y, out_data.pose_y);
          error_count++;
        end
        if (out_data.pose_heading !== want.pose_heading) begin
          $error("pose_heading expected %0h actual %0h",
                 want.pose_heading, out_data.pose_heading);
          error_count++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    idle_enable = 1'b1;
    stall_left  = 0;
    error_count = 0;
    words_sent  = 0;
    poses_checked = 0;
    reg_writes  = 0;
    setups      = 0;
    for (int i = 0; i <= LutSize; i++) sine_lut[i] = quarter_sine(i);
    shadow_cfg.tick_forward_step  = 16'd13940;
    shadow_cfg.tick_sideways_step = 16'd41;
    shadow_cfg.tick_turn_step     = 20'd15673;
    shadow_cfg.start_x            = 32'sd5898240;
    shadow_cfg.start_y            = 32'sd2359296;
    shadow_cfg.start_heading      = 24'h40_0000;
    track_x       = 5898240;
    track_y       = 2359296;
    track_heading = 24'h40_0000;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_saturation();
    test_heading_wrap();
    test_quadrants();
    test_random_traffic();

    drain_poses();
    repeat (ResultLatency + 2) @(posedge clk_i);

    $display("%0d words sent, %0d poses checked against the tracker",
             words_sent, poses_checked);
    $display("%0d register writes over %0d random setups, %0d mismatches",
             reg_writes, setups, error_count);
    if (error_count == 0 && pending_poses.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/eto_pkg.sv
rtl/core/eto_sine_rom.sv
rtl/core/eto_pose_step.sv
rtl/core/encoder_tick_odometry.sv
dv/encoder_tick_odometry_test.sv
